// ----- design/grayscale_kmeans_quantizer_assert.svh -----
// Assertion macros for the k-means quantizer.
`ifndef GRAYSCALE_KMEANS_QUANTIZER_ASSERT_SVH
`define GRAYSCALE_KMEANS_QUANTIZER_ASSERT_SVH
`ifndef ASSERT_OFF
`define GKQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gkq assertion failed");
`define GKQ_NEVER(lbl, expr) \
    `GKQ_ASSERT(lbl, !(expr))
`else
`define GKQ_ASSERT(lbl, prop)
`define GKQ_NEVER(lbl, expr)
`endif
`endif

// ----- design/gkq_pkg.sv -----
package gkq_pkg;
    localparam int PIX_W     = 8;
    localparam int FRAC_W    = 16;
    localparam int MEAN_W    = 24;
    localparam int LABEL_W   = 4;
    localparam int NUM_INIT  = 6;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_PIXELS_DEF   = 1048576;
    localparam int NUM_CLUSTERS_DEF = 6;

    localparam logic [PIX_W-1:0] ITER_RST = 8'd50;
    localparam logic [PIX_W-1:0] INIT_MEAN_RST [NUM_INIT] =
        '{8'd0, 8'd65, 8'd100, 8'd125, 8'd190, 8'd255};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MEAN0 = 3'd0,
        CFG_MEAN1 = 3'd1,
        CFG_MEAN2 = 3'd2,
        CFG_MEAN3 = 3'd3,
        CFG_MEAN4 = 3'd4,
        CFG_MEAN5 = 3'd5,
        CFG_ITER  = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD,
        ST_CMP,
        ST_WR,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_NEXT,
        ST_FRD,
        ST_FOUT
    } t_state;
endpackage

// ----- design/gkq_ram.sv -----
module gkq_ram #(
    parameter int DEPTH = gkq_pkg::MAX_PIXELS_DEF,
    parameter int WIDTH = gkq_pkg::PIX_W
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- design/gkq_div.sv -----
// Restoring divider, one quotient bit per cycle.
module gkq_div #(
    parameter int DVD_W = 44,
    parameter int DVS_W = 21
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DVD_W-1:0]           i_dividend,
    input  logic [DVS_W-1:0]           i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [gkq_pkg::MEAN_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        diff  = trial - {1'b0, r_dvs};
        n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = diff[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b1};
        end else begin
            n_rem = trial[DVS_W-1:0];
            n_quo = {r_quo[DVD_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_rem  <= '0;
                r_quo  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_dvd <= n_dvd;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo[gkq_pkg::MEAN_W-1:0];
endmodule

// ----- design/grayscale_kmeans_quantizer.sv -----
// One-dimensional k-means quantizer for 8-bit grayscale images. Load requests
// (opcode 0) store one pixel each up to MAX_PIXELS; the request with last set
// closes the image and starts clustering, during which busy stays high.
// In each pass every pixel goes through a read state, one compare per mean in
// a single distance/compare unit and a write state; each non-empty cluster's
// new mean comes from one shared restoring divider producing a quotient bit per
// cycle (DVD_W = pixel count width + 24 bits); an empty cluster keeps its mean.
// A fetch request (opcode 1) reads its label through ST_FRD and ST_FOUT and
// returns one result, shown for a single cycle with o_strobe; the receiver
// cannot stall it, so it must take every strobed result. Fetches before any
// clustered image give nothing.
// Configuration writes are always ready; do them only while idle.
`include "grayscale_kmeans_quantizer_assert.svh"
module grayscale_kmeans_quantizer #(
    parameter int MAX_PIXELS   = gkq_pkg::MAX_PIXELS_DEF,
    parameter int NUM_CLUSTERS = gkq_pkg::NUM_CLUSTERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_opcode,
    input  logic [gkq_pkg::PIX_W-1:0]     i_pixel_in,
    input  logic                          i_last_in,
    output logic                          o_strobe,
    output logic [gkq_pkg::PIX_W-1:0]     o_pixel_out,
    output logic [gkq_pkg::LABEL_W-1:0]   o_cluster_label,
    output logic                          o_last_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gkq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gkq_pkg::PIX_W-1:0]     i_cfg_data
);
    localparam int AW    = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;
    localparam int NW    = $clog2(MAX_PIXELS + 1);
    localparam int CW    = $clog2(NUM_CLUSTERS);
    localparam int SW    = NW + gkq_pkg::PIX_W;
    localparam int DVD_W = SW + gkq_pkg::FRAC_W;
    localparam int MW    = gkq_pkg::MEAN_W;
    localparam int PW    = gkq_pkg::PIX_W;
    localparam int LW    = gkq_pkg::LABEL_W;

    localparam logic [gkq_pkg::CFG_IDX_W-1:0] CFG_IDX_W_MEANS =
        gkq_pkg::CFG_IDX_W'(gkq_pkg::NUM_INIT);

    // configuration
    logic [PW-1:0] r_init [gkq_pkg::NUM_INIT];
    logic [PW-1:0] r_iter;

    // clustering state
    gkq_pkg::t_state r_state, n_state;
    logic [MW-1:0] r_mean  [NUM_CLUSTERS];
    logic [SW-1:0] r_sum   [NUM_CLUSTERS];
    logic [NW-1:0] r_count [NUM_CLUSTERS];
    logic [NW-1:0] r_total, r_lptr, r_n, r_fptr;
    logic [PW-1:0] r_pass;
    logic [CW-1:0] r_k, r_best;
    logic [MW-1:0] r_bestd;

    logic          accept, do_load, do_fetch, load_wr;
    logic [NW-1:0] load_cnt;
    logic          k_last, n_last;
    logic [CW-1:0] cl_idx;
    logic [MW-1:0] cl_mean;
    logic [MW-1:0] pix_q, pix_dist;
    logic          closer;
    logic [PW-1:0] img_rd;
    logic [LW-1:0] lbl_rd;
    logic          lbl_we, div_start, div_busy, div_done;
    logic [MW-1:0] div_q;
    logic [MW:0]   rounded;
    logic          lbl_ok;

    assign busy        = (r_state != gkq_pkg::ST_IDLE);
    assign accept      = start && !busy;
    assign do_load     = accept && !i_opcode;
    assign do_fetch    = accept && i_opcode && (r_total != '0);
    assign load_wr     = do_load && (r_lptr < NW'(MAX_PIXELS));
    assign load_cnt    = load_wr ? r_lptr + 1'b1 : r_lptr;
    assign o_cfg_ready = 1'b1;
    assign k_last      = (r_k == CW'(NUM_CLUSTERS - 1));
    assign n_last      = (r_n + 1'b1 == r_total);
    assign lbl_ok      = ({1'b0, lbl_rd} < (LW + 1)'(NUM_CLUSTERS));

    // One index selects the single read of the means.
    always_comb begin
        case (r_state)
            gkq_pkg::ST_FOUT: cl_idx = lbl_rd[CW-1:0];
            gkq_pkg::ST_WR:   cl_idx = r_best;
            default:          cl_idx = r_k;
        endcase
    end
    assign cl_mean = r_mean[cl_idx];

    // Shared distance/compare unit, strict less-than keeps the lower index.
    assign pix_q    = {img_rd, {gkq_pkg::FRAC_W{1'b0}}};
    assign pix_dist = (cl_mean > pix_q) ? cl_mean - pix_q : pix_q - cl_mean;
    assign closer   = (r_k == '0) || (pix_dist < r_bestd);

    assign rounded = {1'b0, cl_mean} + (MW + 1)'(1 << (gkq_pkg::FRAC_W - 1));

    gkq_ram #(.DEPTH(MAX_PIXELS), .WIDTH(PW)) u_image (
        .i_clk   (i_clk),
        .i_we    (load_wr),
        .i_waddr (r_lptr[AW-1:0]),
        .i_wdata (i_pixel_in),
        .i_raddr (r_n[AW-1:0]),
        .o_rdata (img_rd)
    );

    gkq_ram #(.DEPTH(MAX_PIXELS), .WIDTH(LW)) u_label (
        .i_clk   (i_clk),
        .i_we    (lbl_we),
        .i_waddr (r_n[AW-1:0]),
        .i_wdata (LW'(r_best)),
        .i_raddr (r_fptr[AW-1:0]),
        .o_rdata (lbl_rd)
    );

    gkq_div #(.DVD_W(DVD_W), .DVS_W(NW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_sum[r_k], {gkq_pkg::FRAC_W{1'b0}}}),
        .i_divisor  (r_count[r_k]),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gkq_pkg::ST_IDLE: begin
                if (do_load && i_last_in) begin
                    n_state = gkq_pkg::ST_CLEAR;
                end else if (do_fetch) begin
                    n_state = gkq_pkg::ST_FRD;
                end
            end
            gkq_pkg::ST_CLEAR: n_state = gkq_pkg::ST_RD;
            gkq_pkg::ST_RD:    n_state = gkq_pkg::ST_CMP;
            gkq_pkg::ST_CMP: begin
                if (k_last) begin
                    n_state = gkq_pkg::ST_WR;
                end
            end
            gkq_pkg::ST_WR: n_state = n_last ? gkq_pkg::ST_DIV_GO : gkq_pkg::ST_RD;
            gkq_pkg::ST_DIV_GO: begin
                if (r_count[r_k] != '0) begin
                    n_state = gkq_pkg::ST_DIV_WAIT;
                end else if (k_last) begin
                    n_state = gkq_pkg::ST_NEXT;
                end
            end
            gkq_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    n_state = k_last ? gkq_pkg::ST_NEXT : gkq_pkg::ST_DIV_GO;
                end
            end
            gkq_pkg::ST_NEXT: begin
                n_state = (r_pass == PW'(1)) ? gkq_pkg::ST_IDLE : gkq_pkg::ST_CLEAR;
            end
            gkq_pkg::ST_FRD:  n_state = gkq_pkg::ST_FOUT;
            gkq_pkg::ST_FOUT: n_state = gkq_pkg::ST_IDLE;
            default:          n_state = gkq_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        lbl_we    = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            gkq_pkg::ST_WR:     lbl_we    = 1'b1;
            gkq_pkg::ST_DIV_GO: div_start = (r_count[r_k] != '0);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gkq_pkg::ST_IDLE;
            r_init   <= gkq_pkg::INIT_MEAN_RST;
            r_iter   <= gkq_pkg::ITER_RST;
            r_total  <= '0;
            r_lptr   <= '0;
            r_fptr   <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == gkq_pkg::ST_FOUT);
            if (i_cfg_valid) begin
                if (i_cfg_index < CFG_IDX_W_MEANS) begin
                    r_init[i_cfg_index] <= i_cfg_data;
                end else if (i_cfg_index == gkq_pkg::CFG_ITER) begin
                    r_iter <= i_cfg_data;
                end
            end
            if (do_load) begin
                if (i_last_in) begin
                    r_total <= load_cnt;
                    r_lptr  <= '0;
                    r_fptr  <= '0;
                    r_pass  <= (r_iter == '0) ? PW'(1) : r_iter;
                    for (int k = 0; k < NUM_CLUSTERS; k++) begin
                        r_mean[k] <= {r_init[k < gkq_pkg::NUM_INIT ? k : gkq_pkg::NUM_INIT - 1],
                                      {gkq_pkg::FRAC_W{1'b0}}};
                    end
                end else begin
                    r_lptr <= load_cnt;
                end
            end
            if (do_fetch && r_fptr >= r_total) begin
                r_fptr <= '0;
            end
            unique case (r_state)
                gkq_pkg::ST_CLEAR: begin
                    r_n <= '0;
                    for (int k = 0; k < NUM_CLUSTERS; k++) begin
                        r_sum[k]   <= '0;
                        r_count[k] <= '0;
                    end
                end
                gkq_pkg::ST_RD: r_k <= '0;
                gkq_pkg::ST_CMP: begin
                    if (closer) begin
                        r_bestd <= pix_dist;
                        r_best  <= r_k;
                    end
                    r_k <= r_k + 1'b1;
                end
                gkq_pkg::ST_WR: begin
                    r_sum[r_best]   <= r_sum[r_best] + SW'(img_rd);
                    r_count[r_best] <= r_count[r_best] + 1'b1;
                    r_n             <= r_n + 1'b1;
                    r_k             <= '0;
                end
                gkq_pkg::ST_DIV_GO: begin
                    if (r_count[r_k] == '0) begin
                        r_k <= r_k + 1'b1;
                    end
                end
                gkq_pkg::ST_DIV_WAIT: begin
                    if (div_done) begin
                        r_mean[r_k] <= div_q;
                        r_k         <= r_k + 1'b1;
                    end
                end
                gkq_pkg::ST_NEXT: r_pass <= r_pass - 1'b1;
                gkq_pkg::ST_FOUT: begin
                    o_cluster_label <= lbl_rd;
                    o_last_out      <= (r_fptr + 1'b1 == r_total);
                    if (!lbl_ok) begin
                        o_pixel_out <= '0;
                    end else if (rounded[MW]) begin
                        o_pixel_out <= '1;
                    end else begin
                        o_pixel_out <= rounded[MW-1:gkq_pkg::FRAC_W];
                    end
                    r_fptr <= (r_fptr + 1'b1 == r_total) ? '0 : r_fptr + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    `GKQ_ASSERT(a_strobe_src, o_strobe |-> $past(r_state == gkq_pkg::ST_FOUT))
    `GKQ_NEVER(a_div_idle, !busy && div_busy)
    `GKQ_ASSERT(a_fetch_range, r_state == gkq_pkg::ST_FOUT |-> r_fptr < r_total)
    `GKQ_ASSERT(a_run_nonempty, r_state == gkq_pkg::ST_RD |-> r_n < r_total)
endmodule

// ----- bench/tb_grayscale_kmeans_quantizer.sv -----
`default_nettype none

// Bench for the 1-D k-means grayscale quantizer.
// Loads small images, lets the block cluster them, then fetches the pixels back.
// Every accepted request goes through a local predictor, and each strobed result
// is checked field by field against the oldest queued expectation.
module tb_grayscale_kmeans_quantizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIX_W            = gkq_pkg::PIX_W;
    localparam int LABEL_W          = gkq_pkg::LABEL_W;
    localparam int MEAN_W           = gkq_pkg::MEAN_W;
    localparam int NUM_INIT         = gkq_pkg::NUM_INIT;
    localparam int CFG_IDX_W        = gkq_pkg::CFG_IDX_W;
    localparam int NUM_CLUSTERS_DEF = gkq_pkg::NUM_CLUSTERS_DEF;

    localparam int IMG_CAP      = gkq_pkg::MAX_PIXELS_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int SETTLE       = 20;        // cycles for a fetch to drain
    localparam longint CYCLE_LIMIT = 20000000;

    typedef enum bit {OP_LOAD = 1'b0, OP_FETCH = 1'b1} t_op;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [LABEL_W-1:0] label;
        logic               last;
    } t_quant_pixel;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_opcode = 1'b0;
    logic [PIX_W-1:0]     i_pixel_in = '0;
    logic                 i_last_in = 1'b0;
    logic                 o_strobe;
    logic [PIX_W-1:0]     o_pixel_out;
    logic [LABEL_W-1:0]   o_cluster_label;
    logic                 o_last_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [PIX_W-1:0]     i_cfg_data = '0;

    grayscale_kmeans_quantizer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_pixel_in(i_pixel_in), .i_last_in(i_last_in),
        .o_strobe(o_strobe), .o_pixel_out(o_pixel_out),
        .o_cluster_label(o_cluster_label), .o_last_out(o_last_out),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ---------------- predictor state ----------------
    logic [PIX_W-1:0]   init_mean [NUM_INIT];
    logic [PIX_W-1:0]   pass_cfg;
    logic [PIX_W-1:0]   img [IMG_CAP];
    logic [LABEL_W-1:0] lbl [IMG_CAP];
    logic [MEAN_W-1:0]  mean_q [NUM_CLUSTERS_DEF];
    int unsigned        pixel_total, load_ptr, fetch_ptr;

    t_quant_pixel quant_q [$];      // expected fetch results, oldest first
    int  errors;
    int  images_run, pixels_fetched, random_sent;
    bit  idling_on;                 // random gaps between requests
    longint cycles;

    // Full clustering pass set over the loaded image.
    function automatic void cluster_image();
        int unsigned passes, n, k, best;
        logic [31:0] pix, d, best_d;
        logic [31:0] sums [NUM_CLUSTERS_DEF];
        logic [31:0] counts [NUM_CLUSTERS_DEF];
        logic [63:0] q;
        passes = (pass_cfg == 0) ? 1 : pass_cfg;   // zero behaves as one pass
        for (k = 0; k < NUM_CLUSTERS_DEF; k++)
            mean_q[k] = {init_mean[(k < NUM_INIT) ? k : NUM_INIT-1], 16'h0};
        repeat (passes) begin
            for (k = 0; k < NUM_CLUSTERS_DEF; k++) begin
                sums[k] = 0;
                counts[k] = 0;
            end
            for (n = 0; n < pixel_total; n++) begin
                pix = {8'h0, img[n], 16'h0};
                best = 0;
                best_d = (mean_q[0] > pix) ? mean_q[0] - pix : pix - mean_q[0];
                for (k = 1; k < NUM_CLUSTERS_DEF; k++) begin
                    d = (mean_q[k] > pix) ? mean_q[k] - pix : pix - mean_q[k];
                    if (d < best_d) begin   // strict: ties stay at the lower index
                        best_d = d;
                        best = k;
                    end
                end
                lbl[n] = best[LABEL_W-1:0];
                counts[best]++;
                sums[best] += img[n];
            end
            for (k = 0; k < NUM_CLUSTERS_DEF; k++) begin
                if (counts[k] != 0) begin   // empty clusters keep their mean
                    q = {sums[k], 16'h0} / counts[k];
                    mean_q[k] = q[MEAN_W-1:0];
                end
            end
        end
    endfunction

    // Advance the predictor by one accepted request.
    function automatic void predict_request(bit op, logic [PIX_W-1:0] px, bit lst);
        t_quant_pixel r;
        logic [LABEL_W-1:0] l;
        logic [31:0] rnd;
        if (op == OP_LOAD) begin
            if (load_ptr < IMG_CAP) begin
                img[load_ptr] = px;
                load_ptr++;
            end
            if (lst) begin
                pixel_total = load_ptr;
                cluster_image();
                images_run++;
                load_ptr = 0;
                fetch_ptr = 0;
            end
            return;
        end
        if (pixel_total == 0) return;           // nothing clustered yet
        if (fetch_ptr >= pixel_total) fetch_ptr = 0;
        l = lbl[fetch_ptr];
        rnd = (l < NUM_CLUSTERS_DEF) ? ({8'h0, mean_q[l]} + 32'h8000) >> 16 : 32'h0;
        r.pixel = (rnd > 255) ? 8'd255 : rnd[PIX_W-1:0];
        r.label = l;
        r.last = (fetch_ptr + 1 == pixel_total);
        fetch_ptr = r.last ? 0 : fetch_ptr + 1;
        quant_q.push_back(r);
    endfunction

    // ---------------- result checker ----------------
    always @(posedge i_clk) begin
        t_quant_pixel e;
        if (i_rst_n && o_strobe) begin
            if (quant_q.size() == 0) begin
                $display("%0t: unexpected result pix=%0d lbl=%0d last=%0d", $realtime,
                         o_pixel_out, o_cluster_label, o_last_out);
                errors++;
            end else begin
                e = quant_q.pop_front();
                pixels_fetched++;
                if (o_pixel_out !== e.pixel) begin
                    $display("%0t: pixel_out exp %0d got %0d", $realtime, e.pixel,
                             o_pixel_out);
                    errors++;
                end
                if (o_cluster_label !== e.label) begin
                    $display("%0t: cluster_label exp %0d got %0d", $realtime, e.label,
                             o_cluster_label);
                    errors++;
                end
                if (o_last_out !== e.last) begin
                    $display("%0t: last_out exp %0d got %0d", $realtime, e.last,
                             o_last_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------- request driving ----------------
    // start is left high after acceptance; the next send or drop_start
    // decides its value on the following falling edge.
    task automatic send_request(bit op, logic [PIX_W-1:0] px, bit lst);
        @(negedge i_clk);
        start <= 1'b1;
        i_opcode <= op;
        i_pixel_in <= px;
        i_last_in <= lst;
        do @(posedge i_clk); while (busy);
        predict_request(op, px, lst);
    endtask

    task automatic drop_start(int n);
        @(negedge i_clk);
        start <= 1'b0;
        i_opcode <= 1'($urandom_range(0, 1));
        i_pixel_in <= PIX_W'($urandom_range(0, 255));
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic maybe_gap();
        if (idling_on && $urandom_range(0, 3) == 0) drop_start($urandom_range(1, 15));
    endtask

    // Quiesce: all results in, block out of any clustering run.
    task automatic wait_idle();
        drop_start(1);
        while (quant_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
    endtask

    task automatic write_reg(gkq_pkg::t_cfg_idx idx, logic [PIX_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == gkq_pkg::CFG_ITER) pass_cfg = val;
        else init_mean[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(logic [PIX_W-1:0] m0, m1, m2, m3, m4, m5, it);
        wait_idle();
        write_reg(gkq_pkg::CFG_MEAN0, m0);
        write_reg(gkq_pkg::CFG_MEAN1, m1);
        write_reg(gkq_pkg::CFG_MEAN2, m2);
        write_reg(gkq_pkg::CFG_MEAN3, m3);
        write_reg(gkq_pkg::CFG_MEAN4, m4);
        write_reg(gkq_pkg::CFG_MEAN5, m5);
        write_reg(gkq_pkg::CFG_ITER, it);
    endtask

    // Load n pixels (last set on the final one); pixels come from a few levels
    // half the time so clusters actually gather members.
    task automatic load_image(int n);
        logic [PIX_W-1:0] px;
        for (int i = 0; i < n; i++) begin
            px = $urandom_range(0, 1) ? PIX_W'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, 5) * 51);
            send_request(OP_LOAD, px, i == n - 1);
            maybe_gap();
        end
    endtask

    task automatic fetch_pixels(int n);
        for (int i = 0; i < n; i++) begin
            send_request(OP_FETCH, PIX_W'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
            maybe_gap();
        end
    endtask

    // ---------------- tests ----------------
    task automatic test_fetch_before_image();
        fetch_pixels(3);             // no clustered image: no results
    endtask

    task automatic test_reset_config();
        send_request(OP_LOAD, 8'd0, 1'b0);
        send_request(OP_LOAD, 8'd255, 1'b0);
        send_request(OP_LOAD, 8'd128, 1'b0);
        send_request(OP_LOAD, 8'd70, 1'b1);
        fetch_pixels(5);             // wraps past the final pixel
    endtask

    task automatic test_ties_and_extremes();
        // Means spaced by ten below the top one: a pixel halfway between two goes to the lower one.
        write_all(8'd0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd255, 8'd1);
        send_request(OP_LOAD, 8'd5, 1'b0);
        send_request(OP_LOAD, 8'd15, 1'b0);
        send_request(OP_LOAD, 8'd255, 1'b0);
        send_request(OP_LOAD, 8'd0, 1'b1);
        fetch_pixels(4);
        // All means at the top, 255 passes: the first pass ties everything into cluster zero.
        write_all(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        send_request(OP_LOAD, 8'd1, 1'b0);
        send_request(OP_LOAD, 8'd254, 1'b1);
        fetch_pixels(2);
    endtask

    task automatic test_zero_passes();
        write_all(8'd0, 8'd50, 8'd100, 8'd150, 8'd200, 8'd250, 8'd0);
        send_request(OP_LOAD, 8'd90, 1'b0);
        send_request(OP_LOAD, 8'd201, 1'b1);
        fetch_pixels(2);
    endtask

    task automatic test_loads_after_run();
        // Loads without last leave the previous results in place.
        send_request(OP_LOAD, 8'd7, 1'b0);
        send_request(OP_LOAD, 8'd9, 1'b0);
        fetch_pixels(3);
    endtask

    task automatic test_random();
        int n, m, passes;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent > RANDOM_ITEMS * 4 / 5) idling_on = 0;
            else idling_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 9))
                    0:       passes = 50;
                    1:       passes = 255;
                    2:       passes = 0;
                    default: passes = $urandom_range(1, 6);
                endcase
                write_all(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                          PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                          PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                          PIX_W'(passes));
            end
            n = (pass_cfg > 50) ? $urandom_range(1, 4)
              : ($urandom_range(0, 15) == 0 ? 40 : $urandom_range(1, 12));
            case ($urandom_range(0, 5))
                0: begin   // noise: random requests, last now and then
                    repeat (8) begin
                        send_request(1'($urandom_range(0, 1)), PIX_W'($urandom_range(0, 255)),
                                     ($urandom_range(0, 7) == 0) && pass_cfg <= 50);
                        maybe_gap();
                    end
                    random_sent += 8;
                end
                1: begin   // broken image: loads that never close, then fetches
                    for (int i = 0; i < n; i++) send_request(OP_LOAD,
                                                             PIX_W'($urandom_range(0, 255)),
                                                             1'b0);
                    fetch_pixels(n);
                    random_sent += 2 * n;
                end
                default: begin
                    m = n + $urandom_range(0, n);
                    load_image(n);
                    fetch_pixels(m);
                    random_sent += n + m;
                end
            endcase
        end
    endtask

    initial begin
        for (int k = 0; k < NUM_INIT; k++) init_mean[k] = gkq_pkg::INIT_MEAN_RST[k];
        pass_cfg = gkq_pkg::ITER_RST;
        pixel_total = 0;
        load_ptr = 0;
        fetch_ptr = 0;
        errors = 0;
        images_run = 0;
        pixels_fetched = 0;
        random_sent = 0;
        cycles = 0;
        idling_on = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_fetch_before_image();
        test_reset_config();
        test_ties_and_extremes();
        test_zero_passes();
        test_loads_after_run();
        test_random();

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        $display("covered %0d clustered images and %0d fetched pixels", images_run,
                 pixels_fetched);
        $display("random part sent %0d requests; %0d field errors", random_sent, errors);
        if (errors == 0 && quant_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- files.f -----
+incdir+design
design/gkq_pkg.sv
design/gkq_ram.sv
design/gkq_div.sv
design/grayscale_kmeans_quantizer.sv
bench/tb_grayscale_kmeans_quantizer.sv
